// ===== rtl/sha_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_pkg
// shared types, constants and round functions for the sha-256 block
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam int unsigned WordW = 32;

    typedef logic [WordW-1:0] t_word;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       empty_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    // buffer write source
    typedef enum logic [1:0] {
        BUF_DATA = 2'd0,
        BUF_PAD  = 2'd1,
        BUF_ZERO = 2'd2,
        BUF_LEN  = 2'd3
    } t_buf_sel;

    // commands from controller to datapath
    typedef struct packed {
        logic       buf_wr;
        t_buf_sel   buf_sel;
        logic [5:0] buf_addr;
        logic       len_inc;
        logic       round_init;
        logic       round_step;
        logic [5:0] round_num;
        logic       hash_update;
        logic       hash_reset;
        logic       out_load;
        logic [2:0] out_idx;
    } t_cmd;

    localparam t_word H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    function automatic t_word ror(input t_word x, input int unsigned amt);
        ror = (x >> amt) | (x << (WordW - amt));
    endfunction

endpackage

// ===== rtl/sha_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_stream_if
// valid/ready channel carrying one item
// ----------------------------------------------------------------------------
interface sha_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/sha256_message_digest.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_message_digest
// sha-256 over a byte stream, digest as eight 32-bit words
// ----------------------------------------------------------------------------
// a plain byte goes into the block buffer; the 64th byte of a block adds a
// compression (one shared round unit, one round per cycle, plus load and hash
// add); message end: pad fill from end position to byte 63, length in bytes
// 56 to 63, compression; a pad byte at 56 or above adds a compression and a
// zero block; then a load and eight words at one per cycle while ready is high
// synchronous active-low reset returns the hash to its initial values
module sha256_message_digest (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sha_stream_if.sink   in_ch,
    sha_stream_if.source out_ch
);
    sha_pkg::t_cmd  cmd;
    logic [5:0]     len_pos;
    sha_pkg::t_word digest;
    logic [2:0]     out_idx;

    sha_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .i_last_byte (in_ch.data.last_byte),
        .i_empty     (in_ch.data.empty_message),
        .o_in_ready  (in_ch.ready),
        .i_len_pos   (len_pos),
        .o_cmd       (cmd),
        .o_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready),
        .o_out_idx   (out_idx)
    );

    sha_datapath u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_byte    (in_ch.data.data_byte),
        .o_len_pos (len_pos),
        .o_digest  (digest)
    );

    assign out_ch.data.digest_word = digest;
    assign out_ch.data.word_index  = out_idx;
    assign out_ch.data.last_word   = (out_idx == 3'd7);
endmodule

// ===== rtl/sha_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_datapath
// block buffer, length counter, schedule, round unit and hash words
// ----------------------------------------------------------------------------
module sha_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sha_pkg::t_cmd     i_cmd,
    input  logic [7:0]        i_byte,
    output logic [5:0]        o_len_pos,
    output sha_pkg::t_word    o_digest
);
    // block held as sixteen big-endian words, written one byte lane at a time
    sha_pkg::t_word       r_buf [16];
    logic [60:0]          r_len;
    sha_pkg::t_word       r_w [16];
    sha_pkg::t_word       r_v [8];
    sha_pkg::t_word       r_h [8];
    sha_pkg::t_word       r_out;

    logic [7:0]           n_buf_byte;
    logic [63:0]          bits;
    sha_pkg::t_word       wt, w15, w2, s0, s1, e1, a0, ch, maj, t1, t2;
    logic [3:0]           widx;
    logic [2:0]           lsel;
    logic [1:0]           lane;

    assign bits      = {r_len, 3'b000};
    assign o_len_pos = r_len[5:0];
    assign o_digest  = r_out;
    assign lsel      = i_cmd.buf_addr[2:0];
    assign lane      = i_cmd.buf_addr[1:0];
    assign widx      = i_cmd.round_num[3:0];

    always_comb begin
        case (i_cmd.buf_sel)
            sha_pkg::BUF_DATA: n_buf_byte = i_byte;
            sha_pkg::BUF_PAD:  n_buf_byte = sha_pkg::PAD_BYTE;
            sha_pkg::BUF_ZERO: n_buf_byte = 8'h00;
            default:           n_buf_byte = bits[8*(7-lsel) +: 8];
        endcase
    end

    // message schedule and round logic
    always_comb begin
        w15 = r_w[widx + 4'd1];
        w2  = r_w[widx + 4'd14];
        s0  = sha_pkg::ror(w15, 7) ^ sha_pkg::ror(w15, 18) ^ (w15 >> 3);
        s1  = sha_pkg::ror(w2, 17) ^ sha_pkg::ror(w2, 19) ^ (w2 >> 10);
        if (i_cmd.round_num < 6'd16) begin
            wt = r_buf[widx];
        end else begin
            wt = r_w[widx] + s0 + r_w[widx + 4'd9] + s1;
        end
        e1  = sha_pkg::ror(r_v[4], 6) ^ sha_pkg::ror(r_v[4], 11)
            ^ sha_pkg::ror(r_v[4], 25);
        ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1  = r_v[7] + e1 + ch + sha_pkg::ROUND_K[i_cmd.round_num] + wt;
        a0  = sha_pkg::ror(r_v[0], 2) ^ sha_pkg::ror(r_v[0], 13)
            ^ sha_pkg::ror(r_v[0], 22);
        maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t2  = a0 + maj;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.buf_wr) begin
            r_buf[i_cmd.buf_addr[5:2]][8*(3-lane) +: 8] <= n_buf_byte;
        end
        if (i_cmd.round_init) begin
            r_v <= r_h;
        end else if (i_cmd.round_step) begin
            r_w[widx] <= wt;
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
        if (i_cmd.out_load) begin
            r_out <= r_h[i_cmd.out_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_h   <= sha_pkg::H_INIT;
        end else begin
            if (i_cmd.hash_reset) begin
                r_len <= '0;
                r_h   <= sha_pkg::H_INIT;
            end else begin
                if (i_cmd.len_inc) begin
                    r_len <= r_len + 61'd1;
                end
                if (i_cmd.hash_update) begin
                    for (int i = 0; i < 8; i++) begin
                        r_h[i] <= r_h[i] + r_v[i];
                    end
                end
            end
        end
    end
endmodule

// ===== rtl/sha_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_controller
// sequences absorb, padding, compression and digest output
// ----------------------------------------------------------------------------
module sha_controller (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_last_byte,
    input  logic          i_empty,
    output logic          o_in_ready,
    input  logic [5:0]    i_len_pos,
    output sha_pkg::t_cmd o_cmd,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [2:0]    o_out_idx
);
    typedef enum logic [2:0] {
        S_IDLE, S_PAD, S_LEN, S_INIT, S_ROUND, S_ADD, S_OUT
    } t_state;

    t_state     r_state;
    logic [5:0] r_cnt;
    logic       r_final;   // compression belongs to message end
    logic       r_second;  // another padding block follows this compression
    logic       r_zfill;   // padding pass without the pad byte
    logic [2:0] r_idx;
    logic       r_ovalid;
    // output of word 0 loads in the cycle after the hash add
    logic       r_load0;
    logic       accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_ovalid;
    assign o_out_idx   = r_idx;

    always_comb begin
        o_cmd = '0;
        o_cmd.round_num = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (accept && !i_empty) begin
                    o_cmd.buf_wr   = 1'b1;
                    o_cmd.buf_sel  = sha_pkg::BUF_DATA;
                    o_cmd.buf_addr = i_len_pos;
                    o_cmd.len_inc  = 1'b1;
                end
            end
            S_PAD: begin
                o_cmd.buf_wr   = 1'b1;
                o_cmd.buf_sel  = (!r_zfill && r_cnt == i_len_pos) ? sha_pkg::BUF_PAD
                                                                   : sha_pkg::BUF_ZERO;
                o_cmd.buf_addr = r_cnt;
            end
            S_LEN: begin
                o_cmd.buf_wr   = 1'b1;
                o_cmd.buf_sel  = sha_pkg::BUF_LEN;
                o_cmd.buf_addr = r_cnt;
            end
            S_INIT:  o_cmd.round_init = 1'b1;
            S_ROUND: o_cmd.round_step = 1'b1;
            S_ADD:   o_cmd.hash_update = 1'b1;
            S_OUT: begin
                if (r_load0) begin
                    o_cmd.out_idx  = 3'd0;
                    o_cmd.out_load = 1'b1;
                end else begin
                    o_cmd.out_idx  = r_idx + 3'd1;
                    o_cmd.out_load = r_ovalid && i_out_ready && (r_idx != 3'd7);
                    o_cmd.hash_reset = r_ovalid && i_out_ready && (r_idx == 3'd7);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_final  <= 1'b0;
            r_second <= 1'b0;
            r_zfill  <= 1'b0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
            r_load0  <= 1'b0;
        end else begin
            r_load0 <= (r_state == S_ADD) && r_final;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (!i_empty && i_len_pos == 6'd63) begin
                            // full block first; on a last byte, padding then starts a fresh block
                            r_state  <= S_INIT;
                            r_final  <= 1'b0;
                            r_second <= i_last_byte;
                            r_zfill  <= 1'b0;
                        end else if (i_empty || i_last_byte) begin
                            r_state  <= S_PAD;
                            r_final  <= 1'b0;
                            r_second <= 1'b0;
                            r_zfill  <= 1'b0;
                            // position after this byte, or the current position for an empty message
                            r_cnt    <= i_empty ? i_len_pos : i_len_pos + 6'd1;
                        end
                    end
                end
                S_PAD: begin
                    if (r_cnt == 6'd63) begin
                        if (!r_zfill && i_len_pos >= sha_pkg::LEN_POS) begin
                            // no room for the length, zero block follows
                            r_second <= 1'b1;
                            r_zfill  <= 1'b1;
                            r_state  <= S_INIT;
                        end else begin
                            r_state  <= S_LEN;
                            r_cnt    <= sha_pkg::LEN_POS;
                        end
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_LEN: begin
                    if (r_cnt == 6'd63) begin
                        r_state <= S_INIT;
                        r_final <= 1'b1;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_INIT: begin
                    r_state <= S_ROUND;
                    r_cnt   <= '0;
                end
                S_ROUND: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    if (r_final) begin
                        r_state <= S_OUT;
                        r_idx   <= '0;
                    end else if (r_second) begin
                        r_second <= 1'b0;
                        r_state  <= S_PAD;
                        r_cnt    <= '0;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_OUT: begin
                    if (r_load0) begin
                        r_ovalid <= 1'b1;
                    end else if (r_ovalid && i_out_ready) begin
                        r_idx <= r_idx + 3'd1;
                        if (r_idx == 3'd7) begin
                            r_ovalid <= 1'b0;
                            r_final  <= 1'b0;
                            r_state  <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/sha_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_checker
// port-level checks on the digest stream and the input handshake
// ----------------------------------------------------------------------------
module sha_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_out_idx,
    input logic        i_out_last
);
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_last == (i_out_idx == 3'd7)))
        else $error("last_word mismatch");
    a_no_in_during_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input taken during digest output");
    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_out_last) |=> (i_out_valid
            && i_out_idx == $past(i_out_idx) + 3'd1))
        else $error("word index did not advance");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_idx)))
        else $error("stalled item changed");
endmodule

bind sha256_message_digest sha_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (in_ch.valid),
    .i_in_ready  (in_ch.ready),
    .i_out_valid (out_ch.valid),
    .i_out_ready (out_ch.ready),
    .i_out_idx   (out_ch.data.word_index),
    .i_out_last  (out_ch.data.last_word)
);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives directed and random-length byte-stream messages through the sha-256
// block and checks every digest word against an in-bench sha-256 predictor
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned CycleLimit = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    sha_stream_if #(.T(sha_pkg::t_in_item))  in_ch ();
    sha_stream_if #(.T(sha_pkg::t_out_item)) out_ch ();

    sha256_message_digest u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #2 i_clk = ~i_clk;

    // predictor state
    logic [31:0]  hash_st [8];
    logic [7:0]   blk [64];
    int unsigned  blk_fill;
    logic [60:0]  msg_bytes;

    sha_pkg::t_out_item digest_q [$];
    int unsigned  n_fail;
    int unsigned  cycle_cnt;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic sha_compress();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        for (int t = 0; t < 16; t++) begin
            w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
        end
        for (int t = 16; t < 64; t++) begin
            s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = w[t-16] + s0 + w[t-7] + s1;
        end
        {a, b, c, d, e, f, g, h} = {hash_st[0], hash_st[1], hash_st[2], hash_st[3],
                                    hash_st[4], hash_st[5], hash_st[6], hash_st[7]};
        for (int t = 0; t < 64; t++) begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
                 + sha_pkg::ROUND_K[t] + w[t];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_st[0] += a; hash_st[1] += b; hash_st[2] += c; hash_st[3] += d;
        hash_st[4] += e; hash_st[5] += f; hash_st[6] += g; hash_st[7] += h;
    endtask

    task automatic predict_digest(input sha_pkg::t_in_item it);
        logic [63:0] bit_len;
        sha_pkg::t_out_item r;
        if (!it.empty_message) begin
            blk[blk_fill] = it.data_byte;
            msg_bytes++;
            blk_fill++;
            if (blk_fill == 64) begin
                sha_compress();
                blk_fill = 0;
            end
            if (!it.last_byte) return;
        end
        blk[blk_fill] = 8'h80;
        for (int i = blk_fill + 1; i < 64; i++) blk[i] = 8'h00;
        if (blk_fill >= 56) begin
            sha_compress();
            for (int i = 0; i < 64; i++) blk[i] = 8'h00;
        end
        bit_len = {msg_bytes, 3'b000};
        for (int i = 0; i < 8; i++) blk[56+i] = bit_len[63-8*i -: 8];
        sha_compress();
        for (int i = 0; i < 8; i++) begin
            r.digest_word = hash_st[i];
            r.word_index  = 3'(i);
            r.last_word   = (i == 7);
            digest_q.push_back(r);
        end
        foreach (hash_st[i]) hash_st[i] = sha_pkg::H_INIT[i];
        blk_fill  = 0;
        msg_bytes = '0;
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // valid stays high after an accept until the next item or a gap replaces it
    task automatic send_byte(input logic [7:0] d, input logic last, input logic empty);
        sha_pkg::t_in_item it;
        int unsigned gap;
        it.data_byte = d;
        it.last_byte = last;
        it.empty_message = empty;
        gap = pick_gap();
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            in_ch.data  <= '{data_byte: 8'($urandom), last_byte: 1'($urandom),
                             empty_message: 1'($urandom)};
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_digest(it);
        @(negedge i_clk);
    endtask

    task automatic send_message(input int unsigned len);
        for (int i = 0; i < len; i++) begin
            send_byte(8'($urandom), (i == len - 1), 1'b0);
        end
    endtask

    task automatic test_directed_edges();
        send_byte(8'h00, 1'b0, 1'b1);          // empty message up front
        send_byte(8'hff, 1'b0, 1'b0);          // two bytes then empty flag ends it
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h5a, 1'b1, 1'b1);          // flag wins over last
        send_byte(8'h00, 1'b1, 1'b0);          // one-byte messages at the extremes
        send_byte(8'hff, 1'b1, 1'b0);
        send_byte(8'ha5, 1'b0, 1'b0);
        send_byte(8'h3c, 1'b1, 1'b0);
    endtask

    // last byte closing a full block, then a pad byte at 56 forcing a zero block
    task automatic test_pad_boundaries();
        send_message(64);
        for (int i = 0; i < 56; i++) send_byte(8'($urandom), 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);
    endtask

    task automatic test_random_messages();
        int unsigned sent;
        int unsigned len;
        sent = 0;
        while (sent < 12) begin
            if ($urandom_range(0, 4) == 0) begin
                send_byte(8'($urandom), 1'($urandom), 1'b1);
                sent++;
            end else begin
                len = $urandom_range(1, 6);
                send_message(len);
                sent += len;
            end
        end
    endtask

    // receiver stall pattern, with quiet stretches
    initial begin
        int unsigned stall;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            stall = pick_gap();
            if ($urandom_range(0, 3) == 0 && stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(0, 20)) @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        sha_pkg::t_out_item got, want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            if (digest_q.size() == 0) begin
                $display("%0t: unexpected digest word %h idx %0d", $time,
                         got.digest_word, got.word_index);
                n_fail++;
            end else begin
                want = digest_q.pop_front();
                if (got.digest_word !== want.digest_word) begin
                    $display("%0t: digest_word exp %h got %h", $time,
                             want.digest_word, got.digest_word);
                    n_fail++;
                end
                if (got.word_index !== want.word_index) begin
                    $display("%0t: word_index exp %0d got %0d", $time,
                             want.word_index, got.word_index);
                    n_fail++;
                end
                if (got.last_word !== want.last_word) begin
                    $display("%0t: last_word exp %0b got %0b", $time,
                             want.last_word, got.last_word);
                    n_fail++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CycleLimit) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        n_fail = 0;
        cycle_cnt = 0;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        foreach (hash_st[i]) hash_st[i] = sha_pkg::H_INIT[i];
        blk_fill  = 0;
        msg_bytes = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_edges();
        test_pad_boundaries();
        test_random_messages();
        in_ch.valid <= 1'b0;

        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/sha_pkg.sv
rtl/sha_stream_if.sv
rtl/sha_datapath.sv
rtl/sha_controller.sv
rtl/sha256_message_digest.sv
rtl/sha_checker.sv
verif/tb.sv
